### rtl/gbe_pkg.sv
// Shared types and constants for the grid escape walker.
`default_nettype none
package gbe_pkg;

	localparam int GRID_WIDTH  = 32;
	localparam int GRID_HEIGHT = 16;

	localparam logic [1:0] CMD_PLACE = 2'd0;
	localparam logic [1:0] CMD_MOVE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] ST_PLACED  = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_MOVED   = 3'd2;
	localparam logic [2:0] ST_ESCAPED = 3'd3;
	localparam logic [2:0] ST_TRAPPED = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic [2:0] REG_EXIT_LEFT   = 3'd0;
	localparam logic [2:0] REG_EXIT_RIGHT  = 3'd1;
	localparam logic [2:0] REG_EXIT_TOP    = 3'd2;
	localparam logic [2:0] REG_EXIT_BOTTOM = 3'd3;
	localparam logic [2:0] REG_START_COL   = 3'd4;
	localparam logic [2:0] REG_START_ROW   = 3'd5;

	localparam logic [4:0] EXIT_LEFT_RST   = 5'd2;
	localparam logic [4:0] EXIT_RIGHT_RST  = 5'd17;
	localparam logic [3:0] EXIT_TOP_RST    = 4'd2;
	localparam logic [3:0] EXIT_BOTTOM_RST = 4'd7;
	localparam logic [4:0] START_COL_RST   = 5'd9;
	localparam logic [3:0] START_ROW_RST   = 4'd5;

	localparam logic [3:0] NB_COUNT = 4'd9;
	localparam int CMP_W = 8;

	typedef struct packed {
		logic [4:0] exit_left;
		logic [4:0] exit_right;
		logic [3:0] exit_top;
		logic [3:0] exit_bottom;
		logic [4:0] start_col;
		logic [3:0] start_row;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       sweep_wall;
		logic       sweep_dist;
		logic       place_rd;
		logic       place_wr;
		logic       start_walk;
		logic       nb_issue;
		logic       expand_chk;
		logic       deq_rd;
		logic       deq_ld;
		logic       here_rd;
		logic       here_ld;
		logic       trace_take;
		logic       nb_clr;
		logic       set_cat;
		logic       set_start;
		logic       done;
		logic [2:0] res;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd_code;
		logic       sweep_last;
		logic       place_ok;
		logic       cat_in_grid;
		logic       nb_done;
		logic       q_empty;
		logic       here_exit;
		logic       dhere_gt2;
		logic       trace_match;
		logic       out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

### rtl/gbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/gbe_ctrl.sv
// Controller state machine sequencing place, clear, search and traceback.
`default_nettype none
module gbe_ctrl import gbe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t st
);

	typedef enum logic [4:0] {
		S_RST_SWEEP, S_IDLE, S_DECODE, S_PL_RD, S_PL_CHK, S_CLR_SWEEP,
		S_MV_SWEEP, S_MV_START, S_EX_ISSUE, S_EX_CHK, S_DEQ_RD, S_DEQ_LD,
		S_HERE_RD, S_HERE_LD, S_TR_TEST, S_TR_ISSUE, S_TR_CHK, S_MV_END, S_FINISH
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] res_q, res_d;
	logic       stall_q;

	always_comb begin
		cmd     = '0;
		cmd.res = res_q;
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			S_RST_SWEEP: begin
				cmd.sweep_wall = 1'b1;
				if (st.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.cmd_code)
					CMD_PLACE: state_d = S_PL_RD;
					CMD_MOVE:  state_d = S_MV_SWEEP;
					CMD_CLEAR: state_d = S_CLR_SWEEP;
					default: begin
						res_d   = ST_REFUSED;
						state_d = S_FINISH;
					end
				endcase
			end
			S_PL_RD: begin
				cmd.place_rd = 1'b1;
				state_d = S_PL_CHK;
			end
			S_PL_CHK: begin
				if (st.place_ok) begin
					cmd.place_wr = 1'b1;
					res_d = ST_PLACED;
				end else begin
					res_d = ST_REFUSED;
				end
				state_d = S_FINISH;
			end
			S_CLR_SWEEP: begin
				cmd.sweep_wall = 1'b1;
				if (st.sweep_last) begin
					cmd.set_start = 1'b1;
					res_d   = ST_CLEARED;
					state_d = S_FINISH;
				end
			end
			S_MV_SWEEP: begin
				cmd.sweep_dist = 1'b1;
				if (st.sweep_last) state_d = S_MV_START;
			end
			S_MV_START: begin
				if (!st.cat_in_grid) begin
					res_d   = ST_TRAPPED;
					state_d = S_FINISH;
				end else begin
					cmd.start_walk = 1'b1;
					state_d = S_EX_ISSUE;
				end
			end
			S_EX_ISSUE: begin
				cmd.nb_issue = 1'b1;
				state_d = S_EX_CHK;
			end
			S_EX_CHK: begin
				cmd.expand_chk = 1'b1;
				state_d = st.nb_done ? S_DEQ_RD : S_EX_ISSUE;
			end
			S_DEQ_RD: begin
				if (st.q_empty) begin
					res_d   = ST_TRAPPED;
					state_d = S_FINISH;
				end else begin
					cmd.deq_rd = 1'b1;
					state_d = S_DEQ_LD;
				end
			end
			S_DEQ_LD: begin
				cmd.deq_ld = 1'b1;
				state_d = S_HERE_RD;
			end
			S_HERE_RD: begin
				cmd.here_rd = 1'b1;
				cmd.nb_clr  = 1'b1;
				state_d = S_HERE_LD;
			end
			S_HERE_LD: begin
				cmd.here_ld = 1'b1;
				state_d = st.here_exit ? S_TR_TEST : S_EX_ISSUE;
			end
			S_TR_TEST: begin
				cmd.nb_clr = 1'b1;
				state_d = st.dhere_gt2 ? S_TR_ISSUE : S_MV_END;
			end
			S_TR_ISSUE: begin
				cmd.nb_issue = 1'b1;
				state_d = S_TR_CHK;
			end
			S_TR_CHK: begin
				cmd.trace_take = 1'b1;
				if (st.trace_match) state_d = S_TR_TEST;
				else if (st.nb_done) state_d = S_MV_END;
				else state_d = S_TR_ISSUE;
			end
			S_MV_END: begin
				cmd.set_cat = 1'b1;
				res_d   = st.here_exit ? ST_ESCAPED : ST_MOVED;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_SWEEP;
			res_q   <= ST_REFUSED;
			stall_q <= 1'b1;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

	assign in_stall = stall_q;

endmodule
`default_nettype wire

### rtl/gbe_dp.sv
// Datapath: wall, distance and queue memories, walker and search registers.
`default_nettype none
module gbe_dp import gbe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        st,
	input  wire logic [1:0] command,
	input  wire logic [4:0] pos_col,
	input  wire logic [3:0] pos_row,
	input  wire logic       out_stall,
	output logic            out_valid,
	output logic [2:0]      status,
	output logic [4:0]      new_cat_col,
	output logic [3:0]      new_cat_row
);

	localparam int CW     = $clog2(GRID_WIDTH);
	localparam int RW     = $clog2(GRID_HEIGHT);
	localparam int AW     = CW + RW;
	localparam int DEPTH  = 1 << AW;
	localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int DW     = $clog2(NCELLS + 2);
	localparam int QW     = AW + 1;
	localparam logic [CMP_W-1:0] GW = CMP_W'(GRID_WIDTH);
	localparam logic [CMP_W-1:0] GH = CMP_W'(GRID_HEIGHT);

	logic [1:0]    cmd_q;
	logic [4:0]    pcol_q, cat_col_q;
	logic [3:0]    prow_q, cat_row_q;
	logic [CW-1:0] hc_q, nc_q;
	logic [RW-1:0] hr_q, nr_q;
	logic          nok_q;
	logic [DW-1:0] dhere_q;
	logic [3:0]    nb_q;
	logic [QW-1:0] head_q, tail_q;
	logic [AW-1:0] sweep_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [4:0]    ocol_q;
	logic [3:0]    orow_q;

	logic [CMP_W-1:0] drow, dcol, nc_w, nr_w, pc8, pr8, cc8, cr8, hc8, hr8, nc8, nr8;
	logic             n_ok, fresh, push, match;
	logic [AW-1:0]    n_adr, nq_adr, pos_adr, cat_adr, here_adr;
	logic             wall_we, wall_wd, wall_rd;
	logic [AW-1:0]    wall_wa, wall_ra;
	logic             dist_we;
	logic [DW-1:0]    dist_wd, dist_rd;
	logic [AW-1:0]    dist_wa, dist_ra;
	logic [AW-1:0]    q_rd;

	function automatic logic on_border(input logic [CMP_W-1:0] c, input logic [CMP_W-1:0] r);
		on_border = (c == '0) || (c == GW - 1'b1) || (r == '0) || (r == GH - 1'b1);
	endfunction

	function automatic logic on_exit(input cfg_t k, input logic [CMP_W-1:0] c,
		input logic [CMP_W-1:0] r);
		on_exit = (c + 1'b1 == CMP_W'(k.exit_left)) || (c == CMP_W'(k.exit_right) + 1'b1) ||
			(r + 1'b1 == CMP_W'(k.exit_top)) || (r == CMP_W'(k.exit_bottom) + 1'b1);
	endfunction

	always_comb begin
		if (nb_q >= 4'd6) drow = CMP_W'(1);
		else if (nb_q >= 4'd3) drow = '0;
		else drow = '1;
		case (nb_q) inside
			4'd0, 4'd3, 4'd6: dcol = '1;
			4'd1, 4'd4, 4'd7: dcol = '0;
			default:          dcol = CMP_W'(1);
		endcase
	end

	assign hc8   = CMP_W'(hc_q);
	assign hr8   = CMP_W'(hr_q);
	assign nc8   = CMP_W'(nc_q);
	assign nr8   = CMP_W'(nr_q);
	assign pc8   = CMP_W'(pcol_q);
	assign pr8   = CMP_W'(prow_q);
	assign cc8   = CMP_W'(cat_col_q);
	assign cr8   = CMP_W'(cat_row_q);
	assign nc_w  = hc8 + dcol;
	assign nr_w  = hr8 + drow;
	assign n_ok  = (nc_w < GW) && (nr_w < GH);
	assign n_adr    = {nr_w[RW-1:0], nc_w[CW-1:0]};
	assign nq_adr   = {nr_q, nc_q};
	assign pos_adr  = {pr8[RW-1:0], pc8[CW-1:0]};
	assign cat_adr  = {cr8[RW-1:0], cc8[CW-1:0]};
	assign here_adr = {hr_q, hc_q};

	assign fresh = nok_q && !on_border(nc8, nr8) && !wall_rd && (dist_rd == '0);
	assign push  = cmd.expand_chk && fresh && (tail_q < QW'(NCELLS));
	assign match = nok_q && (dist_rd == dhere_q - 1'b1);

	always_comb begin
		wall_we = cmd.sweep_wall || cmd.place_wr;
		wall_wd = cmd.place_wr;
		wall_wa = cmd.place_wr ? pos_adr : sweep_q;
		wall_ra = cmd.place_rd ? pos_adr : n_adr;
		dist_we = cmd.sweep_dist || cmd.start_walk || (cmd.expand_chk && fresh);
		if (cmd.sweep_dist) begin
			dist_wa = sweep_q;
			dist_wd = '0;
		end else if (cmd.start_walk) begin
			dist_wa = cat_adr;
			dist_wd = DW'(1);
		end else begin
			dist_wa = nq_adr;
			dist_wd = dhere_q + 1'b1;
		end
		dist_ra = cmd.here_rd ? here_adr : n_adr;
	end

	gbe_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_wall (
		.clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
		.raddr(wall_ra), .rdata(wall_rd)
	);

	gbe_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dist (
		.clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
		.raddr(dist_ra), .rdata(dist_rd)
	);

	gbe_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_queue (
		.clk(clk), .we(push), .waddr(tail_q[AW-1:0]), .wdata(nq_adr),
		.raddr(head_q[AW-1:0]), .rdata(q_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			nb_q        <= '0;
			cat_col_q   <= START_COL_RST;
			cat_row_q   <= START_ROW_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_wall || cmd.sweep_dist) sweep_q <= sweep_q + 1'b1;
			if (cmd.start_walk) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.deq_rd) head_q <= head_q + 1'b1;
				if (push) tail_q <= tail_q + 1'b1;
			end
			if (cmd.start_walk || cmd.nb_clr) nb_q <= '0;
			else if (cmd.nb_issue) nb_q <= nb_q + 1'b1;
			if (cmd.set_start) begin
				cat_col_q <= cfg.start_col;
				cat_row_q <= cfg.start_row;
			end else if (cmd.set_cat) begin
				cat_col_q <= hc8[4:0];
				cat_row_q <= hr8[3:0];
			end
			if (cmd.done) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= command;
			pcol_q <= pos_col;
			prow_q <= pos_row;
		end
		if (cmd.start_walk) begin
			hc_q    <= cc8[CW-1:0];
			hr_q    <= cr8[RW-1:0];
			dhere_q <= DW'(1);
		end else if (cmd.deq_ld) begin
			{hr_q, hc_q} <= q_rd;
		end else if (cmd.here_ld) begin
			dhere_q <= dist_rd;
		end else if (cmd.trace_take && match) begin
			hc_q    <= nc_q;
			hr_q    <= nr_q;
			dhere_q <= dhere_q - 1'b1;
		end
		if (cmd.nb_issue) begin
			nc_q  <= nc_w[CW-1:0];
			nr_q  <= nr_w[RW-1:0];
			nok_q <= n_ok;
		end
		if (cmd.done) begin
			status_q <= cmd.res;
			ocol_q   <= cat_col_q;
			orow_q   <= cat_row_q;
		end
	end

	always_comb begin
		st.cmd_code    = cmd_q;
		st.sweep_last  = &sweep_q;
		st.place_ok    = (pc8 < GW) && (pr8 < GH) &&
			!((pcol_q == cat_col_q) && (prow_q == cat_row_q)) &&
			!on_border(pc8, pr8) && !wall_rd;
		st.cat_in_grid = (cc8 < GW) && (cr8 < GH);
		st.nb_done     = (nb_q == NB_COUNT);
		st.q_empty     = (head_q >= tail_q);
		st.here_exit   = on_exit(cfg, hc8, hr8);
		st.dhere_gt2   = (dhere_q > DW'(2));
		st.trace_match = match;
		st.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign new_cat_col = ocol_q;
	assign new_cat_row = orow_q;

`ifndef NO_ASSERTIONS
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= QW'(NCELLS)) else $error("queue tail beyond cell count");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q <= ST_CLEARED)) else $error("bad status code");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> st.out_free) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

### rtl/grid_bfs_escape_step_top.sv
// Top level of the grid escape walker: register port, controller and datapath.
// One transaction in gives one result out. A place command reads the wall memory
// and then checks it and writes it if free; an unknown command goes straight to
// the finish state. Clear sweeps the wall memory over every cell of the map (512
// at the default 32 x 16 grid). A move sweeps the distance memory over every cell,
// then for each searched cell runs nine neighbor read/check pairs plus a dequeue
// (queue read and load, then distance read and load), then traceback steps of
// neighbor read/check pairs; the single read port of each memory sets this. After
// reset the wall memory is swept before the first transaction is taken; register writes are taken throughout.
`default_nettype none
module grid_bfs_escape_step_top import gbe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [4:0]  pos_col,
	input  wire logic [3:0]  pos_row,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [4:0]       new_cat_col,
	output logic [3:0]       new_cat_row
);

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exit_left   <= EXIT_LEFT_RST;
			cfg_q.exit_right  <= EXIT_RIGHT_RST;
			cfg_q.exit_top    <= EXIT_TOP_RST;
			cfg_q.exit_bottom <= EXIT_BOTTOM_RST;
			cfg_q.start_col   <= START_COL_RST;
			cfg_q.start_row   <= START_ROW_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[4:2])
				REG_EXIT_LEFT:   cfg_q.exit_left   <= pwdata[4:0];
				REG_EXIT_RIGHT:  cfg_q.exit_right  <= pwdata[4:0];
				REG_EXIT_TOP:    cfg_q.exit_top    <= pwdata[3:0];
				REG_EXIT_BOTTOM: cfg_q.exit_bottom <= pwdata[3:0];
				REG_START_COL:   cfg_q.start_col   <= pwdata[4:0];
				REG_START_ROW:   cfg_q.start_row   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_EXIT_LEFT:   prdata = 32'(cfg_q.exit_left);
			REG_EXIT_RIGHT:  prdata = 32'(cfg_q.exit_right);
			REG_EXIT_TOP:    prdata = 32'(cfg_q.exit_top);
			REG_EXIT_BOTTOM: prdata = 32'(cfg_q.exit_bottom);
			REG_START_COL:   prdata = 32'(cfg_q.start_col);
			REG_START_ROW:   prdata = 32'(cfg_q.start_row);
			default:         prdata = '0;
		endcase
	end

	gbe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .st(st)
	);

	gbe_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd(cmd), .st(st),
		.command(command), .pos_col(pos_col), .pos_row(pos_row),
		.out_stall(out_stall), .out_valid(out_valid), .status(status),
		.new_cat_col(new_cat_col), .new_cat_row(new_cat_row)
	);

endmodule
`default_nettype wire

### test/grid_bfs_escape_step_top_tb.sv
// Testbench for the grid escape walker: directed table and random commands checked by a BFS predictor.
`timescale 1ns / 100ps
`default_nettype none
module grid_bfs_escape_step_top_tb;
	import gbe_pkg::*;

	localparam int GW = 32;
	localparam int GH = 16;
	localparam int NC = GW * GH;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] col;
		logic [3:0] row;
	} walk_res_t;

	typedef struct {
		logic [1:0] cmd;
		logic [4:0] col;
		logic [3:0] row;
		logic       known;
		walk_res_t  res;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [4:0]  pos_col;
	logic [3:0]  pos_row;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [4:0]  new_cat_col;
	logic [3:0]  new_cat_row;

	grid_bfs_escape_step_top i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .command(command), .pos_col(pos_col),
		.pos_row(pos_row), .out_valid(out_valid), .out_stall(out_stall), .status(status),
		.new_cat_col(new_cat_col), .new_cat_row(new_cat_row)
	);

	bit        walls [NC];
	int        level [NC];
	int        frontier [NC];
	int        cat_c, cat_r;
	int        e_left, e_right, e_top, e_bottom, s_col, s_row;
	walk_res_t pending_results [$];
	int        errors;
	bit        rx_gaps;
	int        rx_wait;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit in_grid(int c, int r);
		return c >= 0 && c < GW && r >= 0 && r < GH;
	endfunction

	function automatic bit is_exit(int c, int r);
		return c == e_left - 1 || c == e_right + 1 || r == e_top - 1 || r == e_bottom + 1;
	endfunction

	function automatic void border_walls();
		for (int i = 0; i < NC; i++)
			walls[i] = (i / GW == 0 || i / GW == GH - 1 || i % GW == 0 || i % GW == GW - 1);
	endfunction

	function automatic logic [2:0] escape_step();
		int here, head, tail, nc, nr, n, found;
		for (int i = 0; i < NC; i++)
			level[i] = 0;
		head = 0;
		tail = 0;
		if (!in_grid(cat_c, cat_r))
			return ST_TRAPPED;
		here = cat_r * GW + cat_c;
		level[here] = 1;
		forever begin
			for (int dr = -1; dr <= 1; dr++)
				for (int dc = -1; dc <= 1; dc++) begin
					nc = here % GW + dc;
					nr = here / GW + dr;
					if (in_grid(nc, nr)) begin
						n = nr * GW + nc;
						if (!walls[n] && level[n] == 0) begin
							level[n] = level[here] + 1;
							if (tail < NC) begin
								frontier[tail] = n;
								tail++;
							end
						end
					end
				end
			if (head >= tail)
				return ST_TRAPPED;
			here = frontier[head];
			head++;
			if (is_exit(here % GW, here / GW))
				break;
		end
		while (level[here] > 2) begin
			found = -1;
			for (int dr = -1; dr <= 1 && found < 0; dr++)
				for (int dc = -1; dc <= 1 && found < 0; dc++) begin
					nc = here % GW + dc;
					nr = here / GW + dr;
					if (in_grid(nc, nr) && level[nr * GW + nc] == level[here] - 1)
						found = nr * GW + nc;
				end
			if (found < 0)
				break;
			here = found;
		end
		cat_c = here % GW;
		cat_r = here / GW;
		return is_exit(cat_c, cat_r) ? ST_ESCAPED : ST_MOVED;
	endfunction

	function automatic walk_res_t predict_step(logic [1:0] cmd, int c, int r);
		walk_res_t res;
		res.status = ST_REFUSED;
		if (cmd == CMD_PLACE) begin
			if (in_grid(c, r) && !(c == cat_c && r == cat_r) && !walls[r * GW + c]) begin
				walls[r * GW + c] = 1'b1;
				res.status = ST_PLACED;
			end
		end else if (cmd == CMD_MOVE) begin
			res.status = escape_step();
		end else if (cmd == CMD_CLEAR) begin
			border_walls();
			cat_c = s_col;
			cat_r = s_row;
			res.status = ST_CLEARED;
		end
		res.col = cat_c[4:0];
		res.row = cat_r[3:0];
		return res;
	endfunction

	task automatic write_reg(logic [2:0] idx, int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_EXIT_LEFT:   e_left = value & 31;
			REG_EXIT_RIGHT:  e_right = value & 31;
			REG_EXIT_TOP:    e_top = value & 15;
			REG_EXIT_BOTTOM: e_bottom = value & 15;
			REG_START_COL:   s_col = value & 31;
			default:         s_row = value & 15;
		endcase
	endtask

	task automatic send_step(logic [1:0] cmd, logic [4:0] c, logic [3:0] r);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pending_results.push_back(predict_step(cmd, c, r));
		in_valid <= 1'b1;
		command <= cmd;
		pos_col <= c;
		pos_row <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic bit predict_copy_ok(step_row_t s);
		walk_res_t r;
		int sc, sr;
		bit w;
		sc = cat_c;
		sr = cat_r;
		w = (s.col < GW && s.row < GH) ? walls[s.row * GW + s.col] : 1'b0;
		if (s.cmd == CMD_MOVE)
			return 1'b1;
		r = predict_step(s.cmd, s.col, s.row);
		if (s.cmd == CMD_PLACE && r.status == ST_PLACED)
			walls[s.row * GW + s.col] = w;
		if (s.cmd == CMD_CLEAR)
			return r == s.res;
		cat_c = sc;
		cat_r = sr;
		return r == s.res;
	endfunction

	task automatic send_checked(step_row_t s);
		if (s.known && predict_copy_ok(s) == 1'b0) begin
			errors++;
			$display("%0t: table row %0d/%0d/%0d expected %h predicted differently",
				$time, s.cmd, s.col, s.row, s.res);
		end
		send_step(s.cmd, s.col, s.row);
	endtask

	always @(posedge clk) begin
		walk_res_t got;
		walk_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, new_cat_col, new_cat_row};
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						got.status);
				end
				if (got.col !== want.col) begin
					errors++;
					$display("%0t: new_cat_col expected %0d actual %0d", $time, want.col,
						got.col);
				end
				if (got.row !== want.row) begin
					errors++;
					$display("%0t: new_cat_row expected %0d actual %0d", $time, want.row,
						got.row);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || !rx_gaps) begin
			rx_wait = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				rx_wait = $urandom_range(0, 8);
			else if (rx_wait > 0)
				rx_wait--;
			out_stall <= (rx_wait > 0);
		end
	end

	initial begin
		step_row_t directed [$];
		int        kind;
		logic [1:0] cmd;
		logic [4:0] c;
		logic [3:0] r;
		errors = 0;
		rx_gaps = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = CMD_PLACE;
		pos_col = '0;
		pos_row = '0;
		e_left = EXIT_LEFT_RST;
		e_right = EXIT_RIGHT_RST;
		e_top = EXIT_TOP_RST;
		e_bottom = EXIT_BOTTOM_RST;
		s_col = START_COL_RST;
		s_row = START_ROW_RST;
		cat_c = s_col;
		cat_r = s_row;
		border_walls();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			'{CMD_PLACE, 5'd9,  4'd5,  1'b1, '{ST_REFUSED, 5'd9, 4'd5}},
			'{CMD_PLACE, 5'd0,  4'd0,  1'b1, '{ST_REFUSED, 5'd9, 4'd5}},
			'{CMD_PLACE, 5'd31, 4'd15, 1'b1, '{ST_REFUSED, 5'd9, 4'd5}},
			'{CMD_PLACE, 5'd10, 4'd5,  1'b1, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd10, 4'd5,  1'b1, '{ST_REFUSED, 5'd9, 4'd5}},
			'{2'd3,      5'd31, 4'd15, 1'b1, '{ST_REFUSED, 5'd9, 4'd5}},
			'{CMD_MOVE,  5'd0,  4'd0,  1'b0, '{ST_MOVED,   5'd0, 4'd0}},
			'{CMD_MOVE,  5'd31, 4'd15, 1'b0, '{ST_MOVED,   5'd0, 4'd0}},
			'{CMD_MOVE,  5'd0,  4'd0,  1'b0, '{ST_MOVED,   5'd0, 4'd0}},
			'{CMD_MOVE,  5'd0,  4'd0,  1'b0, '{ST_MOVED,   5'd0, 4'd0}},
			'{CMD_MOVE,  5'd0,  4'd0,  1'b0, '{ST_MOVED,   5'd0, 4'd0}},
			'{CMD_CLEAR, 5'd0,  4'd0,  1'b1, '{ST_CLEARED, 5'd9, 4'd5}},
			'{CMD_PLACE, 5'd8,  4'd4,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd9,  4'd4,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd10, 4'd4,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd8,  4'd5,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd10, 4'd5,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd8,  4'd6,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd9,  4'd6,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_PLACE, 5'd10, 4'd6,  1'b0, '{ST_PLACED,  5'd9, 4'd5}},
			'{CMD_MOVE,  5'd0,  4'd0,  1'b1, '{ST_TRAPPED, 5'd9, 4'd5}},
			'{CMD_CLEAR, 5'd0,  4'd0,  1'b1, '{ST_CLEARED, 5'd9, 4'd5}}
		};
		foreach (directed[i])
			send_checked(directed[i]);
		drain();

		// walker on a border wall in two corners, and on an exit line
		write_reg(REG_START_COL, 0);
		write_reg(REG_START_ROW, 0);
		send_step(CMD_CLEAR, 5'd0, 4'd0);
		send_step(CMD_MOVE, 5'd0, 4'd0);
		send_step(CMD_MOVE, 5'd0, 4'd0);
		drain();
		write_reg(REG_START_COL, 31);
		write_reg(REG_START_ROW, 15);
		send_step(CMD_CLEAR, 5'd0, 4'd0);
		send_step(CMD_MOVE, 5'd0, 4'd0);
		drain();
		write_reg(REG_EXIT_LEFT, 29);
		write_reg(REG_EXIT_RIGHT, 29);
		write_reg(REG_EXIT_TOP, 13);
		write_reg(REG_EXIT_BOTTOM, 13);
		write_reg(REG_START_COL, 30);
		write_reg(REG_START_ROW, 14);
		send_step(CMD_CLEAR, 5'd0, 4'd0);
		send_step(CMD_MOVE, 5'd0, 4'd0);
		send_step(CMD_MOVE, 5'd0, 4'd0);
		drain();
		write_reg(REG_EXIT_LEFT, 2);
		write_reg(REG_EXIT_RIGHT, 2);
		write_reg(REG_EXIT_TOP, 2);
		write_reg(REG_EXIT_BOTTOM, 2);
		write_reg(REG_START_COL, 1);
		write_reg(REG_START_ROW, 1);
		send_step(CMD_CLEAR, 5'd0, 4'd0);
		send_step(CMD_MOVE, 5'd0, 4'd0);
		drain();

		rx_gaps = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_EXIT_LEFT, $urandom_range(2, 29));
			write_reg(REG_EXIT_RIGHT, $urandom_range(2, 29));
			write_reg(REG_EXIT_TOP, $urandom_range(2, 13));
			write_reg(REG_EXIT_BOTTOM, $urandom_range(2, 13));
			write_reg(REG_START_COL, $urandom_range(1, 30));
			write_reg(REG_START_ROW, $urandom_range(1, 14));
			send_step(CMD_CLEAR, 5'd0, 4'd0);
			for (int k = 0; k < 22; k++) begin
				kind = $urandom_range(0, 19);
				c = $urandom_range(0, 31);
				r = $urandom_range(0, 15);
				if (kind < 10)
					cmd = CMD_PLACE;
				else if (kind < 18)
					cmd = CMD_MOVE;
				else if (kind < 19)
					cmd = CMD_CLEAR;
				else
					cmd = 2'd3;
				send_step(cmd, c, r);
				if (k == 15 && phase == 1) begin
					in_valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

### grid_bfs_escape_step_top.f
rtl/gbe_pkg.sv
rtl/gbe_ram.sv
rtl/gbe_ctrl.sv
rtl/gbe_dp.sv
rtl/grid_bfs_escape_step_top.sv
test/grid_bfs_escape_step_top_tb.sv
